[hw/rtl/page_run_allocator_worst_fit_unit_assert.svh]
// Assertion macros used by the checker file pra_checker.
`ifndef PAGE_RUN_ALLOCATOR_WORST_FIT_UNIT_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_WORST_FIT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pra_pkg.sv]
// ----------------------------------------------------------------------------
// pra_pkg
// Types and constants of the worst-fit page run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    localparam int AREA_PAGES = 1024;
    localparam int IDX_W      = 10;
    localparam int PG_W       = 11;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // one memory word per page index; only segment starts are meaningful
    typedef struct packed {
        logic [IDX_W-1:0] prev;
        logic             used;
        logic [PG_W-1:0]  size;
    } seg_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] run_index;
        logic [PG_W-1:0]  run_pages;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/pra_ram.sv]
// ----------------------------------------------------------------------------
// pra_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pra_seq.sv]
// ----------------------------------------------------------------------------
// pra_seq
// Sequencer: segment walk, split, append and coalescing free over the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic                        req_op,
    input  wire logic [pra_pkg::PG_W-1:0]    req_pages,
    input  wire logic [pra_pkg::IDX_W-1:0]   req_index,
    input  wire logic [pra_pkg::PG_W-1:0]    limit,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output pra_pkg::result_t                 res,
    output logic                             ram_we,
    output logic [pra_pkg::IDX_W-1:0]        ram_waddr,
    output pra_pkg::seg_t                    ram_wdata,
    output logic                             ram_re,
    output logic [pra_pkg::IDX_W-1:0]        ram_raddr,
    input  wire pra_pkg::seg_t               ram_rdata
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_WALK   = 15'b000000000000100,
        S_DECIDE = 15'b000000000001000,
        S_SPLB   = 15'b000000000010000,
        S_SPLN   = 15'b000000000100000,
        S_FIDX   = 15'b000000001000000,
        S_FPREV  = 15'b000000010000000,
        S_FAFT   = 15'b000000100000000,
        S_FCHK   = 15'b000001000000000,
        S_FWS    = 15'b000010000000000,
        S_FWI    = 15'b000100000000000,
        S_FWN    = 15'b001000000000000,
        S_RESP   = 15'b010000000000000,
        S_SPARE  = 15'b100000000000000
    } state_t;

    localparam int IW = pra_pkg::IDX_W;
    localparam int PW = pra_pkg::PG_W;
    localparam logic [PW:0] AREA = (PW+1)'(pra_pkg::AREA_PAGES);

    state_t              state_reg, state_next;
    logic [IW-1:0]       clr_reg, clr_next;
    logic [PW-1:0]       brk_reg, brk_next;
    logic [PW-1:0]       req_reg, req_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       last_reg, last_next;
    logic [IW-1:0]       best_reg, best_next;
    logic [PW-1:0]       bsize_reg, bsize_next;
    logic [IW-1:0]       bprev_reg, bprev_next;
    logic [IW-1:0]       start_reg, start_next;
    pra_pkg::seg_t       sw_reg, sw_next;
    logic [IW-1:0]       iprev_reg, iprev_next;
    logic                merged_reg, merged_next;
    logic [IW-1:0]       nxt_reg, nxt_next;
    logic                npend_reg, npend_next;
    pra_pkg::result_t    res_reg, res_next;

    logic [PW:0]         ncur;
    logic [PW:0]         bnext;
    logic [PW:0]         after;
    logic [PW:0]         fnxt;
    logic [PW-1:0]       fsize;
    logic [PW-1:0]       room;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    assign ncur  = {1'b0, cur_reg} + {1'b0, ram_rdata.size};
    assign bnext = {1'b0, PW'(best_reg)} + {1'b0, bsize_reg};
    assign after = {1'b0, PW'(start_reg)} + {1'b0, sw_reg.size};
    assign fsize = sw_reg.size + ram_rdata.size;
    assign fnxt  = {1'b0, PW'(start_reg)} + {1'b0, fsize};
    assign room  = limit - brk_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        brk_next    = brk_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        best_next   = best_reg;
        bsize_next  = bsize_reg;
        bprev_next  = bprev_reg;
        start_next  = start_reg;
        sw_next     = sw_reg;
        iprev_next  = iprev_reg;
        merged_next = merged_reg;
        nxt_next    = nxt_reg;
        npend_next  = npend_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IW'(pra_pkg::AREA_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_pages;
                    idx_next   = req_index;
                    cur_next   = '0;
                    last_next  = '0;
                    bsize_next = '0;
                    npend_next = 1'b0;
                    if (req_op == pra_pkg::OP_ALLOC)
                    begin
                        if (req_pages == '0)
                        begin
                            res_next   = '{pra_pkg::ST_ZERO, '0, '0};
                            state_next = S_RESP;
                        end
                        else if (req_pages > limit)
                        begin
                            res_next   = '{pra_pkg::ST_NOSPACE, '0, '0};
                            state_next = S_RESP;
                        end
                        else if (brk_reg == '0)
                        begin
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        if ({1'b0, req_index} >= brk_reg)
                        begin
                            res_next   = '{pra_pkg::ST_BADFREE, req_index, '0};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = req_index;
                            state_next = S_FIDX;
                        end
                    end
                end
            end
            S_WALK:
            begin
                if (ram_rdata.size == '0)
                begin
                    state_next = S_DECIDE;
                end
                else if (!ram_rdata.used && ram_rdata.size == req_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg[IW-1:0];
                    ram_wdata  = '{ram_rdata.prev, 1'b1, ram_rdata.size};
                    res_next   = '{pra_pkg::ST_OK, cur_reg[IW-1:0], req_reg};
                    state_next = S_RESP;
                end
                else
                begin
                    if (!ram_rdata.used && ram_rdata.size > req_reg
                        && ram_rdata.size > bsize_reg)
                    begin
                        best_next  = cur_reg[IW-1:0];
                        bsize_next = ram_rdata.size;
                        bprev_next = ram_rdata.prev;
                    end
                    last_next = cur_reg[IW-1:0];
                    if (ncur < {1'b0, brk_reg})
                    begin
                        cur_next  = ncur[PW-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = ncur[IW-1:0];
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (bsize_reg != '0)
                begin
                    // split: the tail stays free, best becomes the run
                    start_next = best_reg + req_reg[IW-1:0];
                    ram_we     = 1'b1;
                    ram_waddr  = best_reg + req_reg[IW-1:0];
                    ram_wdata  = '{best_reg, 1'b0, bsize_reg - req_reg};
                    nxt_next   = bnext[IW-1:0];
                    if (bnext < AREA)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = bnext[IW-1:0];
                        npend_next = 1'b1;
                    end
                    state_next = S_SPLB;
                end
                else if (brk_reg > limit || room < req_reg
                         || {1'b0, brk_reg} >= AREA)
                begin
                    res_next   = '{pra_pkg::ST_NOSPACE, '0, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = brk_reg[IW-1:0];
                    ram_wdata  = '{last_reg, 1'b1, req_reg};
                    brk_next   = brk_reg + req_reg;
                    res_next   = '{pra_pkg::ST_OK, brk_reg[IW-1:0], req_reg};
                    state_next = S_RESP;
                end
            end
            S_SPLB:
            begin
                ram_we    = 1'b1;
                ram_waddr = best_reg;
                ram_wdata = '{bprev_reg, 1'b1, req_reg};
                res_next  = '{pra_pkg::ST_OK, best_reg, req_reg};
                state_next = npend_reg ? S_SPLN : S_RESP;
            end
            S_SPLN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nxt_reg;
                ram_wdata  = '{start_reg, ram_rdata.used, ram_rdata.size};
                state_next = S_RESP;
            end
            S_FIDX:
            begin
                if (ram_rdata.size == '0 || !ram_rdata.used)
                begin
                    res_next   = '{pra_pkg::ST_BADFREE, idx_reg, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    res_next    = '{pra_pkg::ST_OK, idx_reg, ram_rdata.size};
                    iprev_next  = ram_rdata.prev;
                    start_next  = idx_reg;
                    sw_next     = '{ram_rdata.prev, 1'b0, ram_rdata.size};
                    merged_next = 1'b0;
                    if (idx_reg != '0 && ram_rdata.prev < idx_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ram_rdata.prev;
                        state_next = S_FPREV;
                    end
                    else
                    begin
                        state_next = S_FAFT;
                    end
                end
            end
            S_FPREV:
            begin
                if (!ram_rdata.used)
                begin
                    start_next  = iprev_reg;
                    sw_next     = '{ram_rdata.prev, 1'b0, ram_rdata.size + res_reg.run_pages};
                    merged_next = 1'b1;
                end
                state_next = S_FAFT;
            end
            S_FAFT:
            begin
                if (after < {1'b0, brk_reg})
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = after[IW-1:0];
                    nxt_next   = after[IW-1:0];
                    state_next = S_FCHK;
                end
                else
                begin
                    brk_next     = PW'(start_reg);
                    sw_next.size = '0;
                    state_next   = S_FWS;
                end
            end
            S_FCHK:
            begin
                // nxt_reg holds the address of the following segment here
                if (ram_rdata.size == '0)
                begin
                    brk_next     = PW'(start_reg);
                    sw_next.size = '0;
                end
                else if (ram_rdata.used)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = nxt_reg;
                    ram_wdata = '{start_reg, 1'b1, ram_rdata.size};
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = nxt_reg;
                    ram_wdata    = '{ram_rdata.prev, 1'b0, '0};
                    sw_next.size = fsize;
                    nxt_next     = fnxt[IW-1:0];
                    if (fnxt < AREA)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = fnxt[IW-1:0];
                        npend_next = 1'b1;
                    end
                end
                state_next = S_FWS;
            end
            S_FWS:
            begin
                ram_we    = 1'b1;
                ram_waddr = start_reg;
                ram_wdata = sw_reg;
                if (merged_reg)
                begin
                    state_next = S_FWI;
                end
                else
                begin
                    state_next = npend_reg ? S_FWN : S_RESP;
                end
            end
            S_FWI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = '{iprev_reg, 1'b0, '0};
                state_next = npend_reg ? S_FWN : S_RESP;
            end
            S_FWN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nxt_reg;
                ram_wdata  = '{start_reg, ram_rdata.used, ram_rdata.size};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            brk_reg    <= '0;
            npend_reg  <= 1'b0;
            merged_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            brk_reg    <= brk_next;
            npend_reg  <= npend_next;
            merged_reg <= merged_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        last_reg  <= last_next;
        best_reg  <= best_next;
        bsize_reg <= bsize_next;
        bprev_reg <= bprev_next;
        start_reg <= start_next;
        sw_reg    <= sw_next;
        iprev_reg <= iprev_next;
        nxt_reg   <= nxt_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

[hw/rtl/page_run_allocator_worst_fit_unit.sv]
// ----------------------------------------------------------------------------
// page_run_allocator_worst_fit_unit
// Worst-fit page run allocator with coalescing free, segment table in RAM.
// ----------------------------------------------------------------------------
// One request at a time. An allocate walks the segment chain one RAM read per
// cycle. The walk is bound by the single read port of the segment RAM. After
// reset the whole RAM is cleared, during which s_tready stays low (cfg writes
// are taken). The result sits in an output register, so the next request is
// taken while it waits.
`default_nettype none

module page_run_allocator_worst_fit_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // request_pages[10:0], free_index[20:11]
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // run_index[9:0], run_pages[20:10]
    output logic      [1:0]  m_tuser,   // status
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata  // usable_pages
);

    localparam int IW = pra_pkg::IDX_W;
    localparam int PW = pra_pkg::PG_W;
    localparam logic [PW-1:0] AREA = PW'(pra_pkg::AREA_PAGES);

    logic [PW-1:0]    usable_reg;
    logic [PW-1:0]    limit;
    logic             res_valid;
    logic             res_ready;
    pra_pkg::result_t res;
    logic             out_valid_reg;
    pra_pkg::result_t out_reg;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    pra_pkg::seg_t    ram_wdata;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    pra_pkg::seg_t    ram_rdata;

    assign limit     = (usable_reg > AREA) ? AREA : usable_reg;
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg    <= AREA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                usable_reg <= cfg_wdata;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.run_pages, out_reg.run_index};

    pra_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (s_tuser),
        .req_pages (s_tdata[10:0]),
        .req_index (s_tdata[20:11]),
        .limit     (limit),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pra_ram #(
        .WIDTH ($bits(pra_pkg::seg_t)),
        .DEPTH (pra_pkg::AREA_PAGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[hw/rtl/pra_checker.sv]
// ----------------------------------------------------------------------------
// pra_checker
// Port-level checks of the page run allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_run_allocator_worst_fit_unit_assert.svh"

module pra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    `PRA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PRA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `PRA_ASSERT_IMPL(a_zero_empty, m_tvalid && m_tuser == pra_pkg::ST_ZERO, m_tdata == 24'd0, "zero-size result carries data")
    `PRA_ASSERT_IMPL(a_ok_pages, m_tvalid && m_tuser == pra_pkg::ST_OK, m_tdata[20:10] != 11'd0, "ok result with no pages")
    // one request at a time: ready drops right after an accepted request
    `PRA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

bind page_run_allocator_worst_fit_unit pra_checker u_pra_checker (.*);

`default_nettype wire
